// ===== design/rar_pkg.sv =====
// Shared types and constants for the rational arithmetic and reduction unit.
// No dependencies; used by every other file of the block.
package rar_pkg;

  // Width of one fraction part and of one result part
  localparam int PART_W = 16;
  localparam int RES_W = 2 * PART_W;
  localparam int MODE_W = 3;

  // Divider iteration counter, one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(PART_W);

  // Multiplier step index: three products per arithmetic word
  localparam int MUL_IDX_W = 2;
  localparam logic [MUL_IDX_W-1:0] MUL_FIRST = 2'd0;
  localparam logic [MUL_IDX_W-1:0] MUL_SECOND = 2'd1;
  localparam logic [MUL_IDX_W-1:0] MUL_LAST = 2'd2;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RED = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [PART_W-1:0] a_num;
    logic signed [PART_W-1:0] a_den;
    logic signed [PART_W-1:0] b_num;
    logic signed [PART_W-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_W-1:0] res_num;
    logic signed [RES_W-1:0] res_den;
    logic                    bad_den;
  } out_word_t;

  // Source of the working result register
  typedef enum logic [2:0] {
    RES_NONE,
    RES_ARITH,
    RES_PASS,
    RES_UNIT,
    RES_REDUCED
  } res_sel_t;

  // Operand pair fed to the shared divider
  typedef enum logic [1:0] {
    DIV_GCD,
    DIV_NUM,
    DIV_DEN
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_SUM,
    S_GCD_TEST,
    S_GCD_DIV,
    S_QN_DIV,
    S_QD_DIV,
    S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic                 load;
    logic                 mul_en;
    logic [MUL_IDX_W-1:0] mul_idx;
    logic                 gcd_init;
    logic                 gcd_swap;
    logic                 div_start;
    div_sel_t             div_sel;
    logic                 save_qn;
    res_sel_t             res_sel;
    logic                 out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              b_num_zero;
    logic              b_den_zero;
    logic              y_zero;
    logic              div_done;
  } dp_stat_t;

endpackage

// ===== design/rar_div.sv =====
// Shared restoring divider: unsigned quotient and remainder, one bit a cycle.
// Depends on rar_pkg.
module rar_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rar_pkg::PART_W-1:0] dividend,
  input  logic [rar_pkg::PART_W-1:0] divisor,
  output logic                       done,
  output logic [rar_pkg::PART_W-1:0] quo,
  output logic [rar_pkg::PART_W-1:0] rem
);

  localparam logic [rar_pkg::DIV_CNT_W-1:0] DIV_LAST =
    rar_pkg::DIV_CNT_W'(rar_pkg::PART_W - 1);

  logic                          busy;
  logic [rar_pkg::DIV_CNT_W-1:0] cnt;
  logic [rar_pkg::PART_W-1:0]    dvs;
  logic [rar_pkg::PART_W+1:0]    rem_sh;
  logic [rar_pkg::PART_W+1:0]    diff;
  logic                          q_bit;

  // One restoring step: shift in next dividend bit, try subtract
  always_comb begin
    rem_sh = {1'b0, rem, quo[rar_pkg::PART_W-1]};
    diff   = rem_sh - {2'b00, dvs};
    q_bit  = ~diff[rar_pkg::PART_W+1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[rar_pkg::PART_W-2:0], q_bit};
      rem <= q_bit ? diff[rar_pkg::PART_W-1:0] : rem_sh[rar_pkg::PART_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  // A start with a zero divisor would give garbage to the gcd loop
  a_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    start |-> divisor != '0)
    else $error("divider started with zero divisor");

  // No restart while an operation is in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("divider restarted while busy");

  // Completion is flagged only once the shift sequence has ended
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");
`endif

endmodule

// ===== design/rar_dp.sv =====
// Datapath: operand capture, shared multiplier, gcd registers, result registers.
// Depends on rar_pkg and rar_div.
module rar_dp (
  input  logic                clk,
  input  logic                rst,
  input  rar_pkg::dp_cmd_t    cmd,
  output rar_pkg::dp_stat_t   stat,
  input  rar_pkg::in_word_t   in_data,
  output rar_pkg::out_word_t  out_data
);

  function automatic logic [rar_pkg::PART_W-1:0] mag(logic signed [rar_pkg::PART_W-1:0] v);
    logic [rar_pkg::PART_W-1:0] u;
    u = v;
    return v[rar_pkg::PART_W-1] ? (~u + 1'b1) : u;
  endfunction

  rar_pkg::in_word_t          op;
  logic signed [rar_pkg::RES_W-1:0] p0, p1, p2;
  logic [rar_pkg::PART_W-1:0] x, y, qn;
  rar_pkg::out_word_t         wres, out_q;

  logic signed [rar_pkg::PART_W-1:0] mul_a, mul_b;
  logic signed [rar_pkg::RES_W-1:0]  prod;
  logic [rar_pkg::PART_W-1:0] mag_bn, mag_bd;
  logic [rar_pkg::PART_W-1:0] div_dvd, div_dvs, div_quo, div_rem;
  logic                       div_done;
  logic signed [rar_pkg::RES_W-1:0] arith_num;
  logic signed [rar_pkg::RES_W-1:0] qn_ext, qd_ext;

  assign mag_bn = mag(op.b_num);
  assign mag_bd = mag(op.b_den);

  // Multiplier operand selection per step
  always_comb begin
    mul_a = op.a_num;
    mul_b = op.b_den;
    case (cmd.mul_idx)
      rar_pkg::MUL_FIRST: begin
        mul_a = op.a_num;
        mul_b = (op.mode == rar_pkg::MODE_MUL) ? op.b_num : op.b_den;
      end
      rar_pkg::MUL_SECOND: begin
        mul_a = op.b_num;
        mul_b = op.a_den;
      end
      default: begin
        mul_a = op.a_den;
        mul_b = (op.mode == rar_pkg::MODE_DIV) ? op.b_num : op.b_den;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Cross-product numerator, wraps modulo 2^32
  always_comb begin
    case (op.mode)
      rar_pkg::MODE_ADD: arith_num = p0 + p1;
      rar_pkg::MODE_SUB: arith_num = p0 - p1;
      default:           arith_num = p0;
    endcase
  end

  // Reduced parts take the sign of the original parts
  assign qn_ext = $signed(rar_pkg::RES_W'(qn));
  assign qd_ext = $signed(rar_pkg::RES_W'(div_quo));

  // Divider operand selection
  always_comb begin
    unique case (cmd.div_sel)
      rar_pkg::DIV_GCD: begin div_dvd = x;      div_dvs = y; end
      rar_pkg::DIV_NUM: begin div_dvd = mag_bn; div_dvs = x; end
      rar_pkg::DIV_DEN: begin div_dvd = mag_bd; div_dvs = x; end
      default:          begin div_dvd = x;      div_dvs = y; end
    endcase
  end

  rar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Operand and product registers
  always_ff @(posedge clk) begin
    if (cmd.load) op <= in_data;
    if (cmd.mul_en) begin
      case (cmd.mul_idx)
        rar_pkg::MUL_FIRST:  p0 <= prod;
        rar_pkg::MUL_SECOND: p1 <= prod;
        default:             p2 <= prod;
      endcase
    end
  end

  // Euclid registers
  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      x <= mag_bn;
      y <= mag_bd;
    end else if (cmd.gcd_swap) begin
      x <= y;
      y <= div_rem;
    end
    if (cmd.save_qn) qn <= div_quo;
  end

  // Working result and output register
  always_ff @(posedge clk) begin
    unique case (cmd.res_sel)
      rar_pkg::RES_ARITH: begin
        wres.res_num <= arith_num;
        wres.res_den <= p2;
        wres.bad_den <= (op.a_den == '0) || (op.b_den == '0) || (p2 == '0);
      end
      rar_pkg::RES_PASS: begin
        wres.res_num <= rar_pkg::RES_W'(op.b_num);
        wres.res_den <= rar_pkg::RES_W'(op.b_den);
        wres.bad_den <= 1'b1;
      end
      rar_pkg::RES_UNIT: begin
        wres.res_num <= '0;
        wres.res_den <= rar_pkg::RES_W'(1);
        wres.bad_den <= 1'b0;
      end
      rar_pkg::RES_REDUCED: begin
        wres.res_num <= op.b_num[rar_pkg::PART_W-1] ? -qn_ext : qn_ext;
        wres.res_den <= op.b_den[rar_pkg::PART_W-1] ? -qd_ext : qd_ext;
        wres.bad_den <= 1'b0;
      end
      default: ;
    endcase
    if (cmd.out_load) out_q <= wres;
  end

  assign out_data = out_q;

  always_comb begin
    stat.mode       = op.mode;
    stat.b_num_zero = (op.b_num == '0);
    stat.b_den_zero = (op.b_den == '0);
    stat.y_zero     = (y == '0);
    stat.div_done   = div_done;
  end

endmodule

// ===== design/rar_ctrl.sv =====
// Controller: sequences multiply steps, Euclid remainder loop and output handoff.
// Depends on rar_pkg.
module rar_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rar_pkg::dp_stat_t stat,
  output rar_pkg::dp_cmd_t  cmd
);

  rar_pkg::state_t state, state_next;
  logic [rar_pkg::MUL_IDX_W-1:0] cnt, cnt_next;
  logic out_valid_next;
  logic arith_mode;

  assign arith_mode = (stat.mode == rar_pkg::MODE_ADD) || (stat.mode == rar_pkg::MODE_SUB) ||
                      (stat.mode == rar_pkg::MODE_MUL) || (stat.mode == rar_pkg::MODE_DIV);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rar_pkg::S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.div_sel    = rar_pkg::DIV_GCD;
    cmd.res_sel    = rar_pkg::RES_NONE;
    cmd.mul_idx    = cnt;
    unique case (state)
      rar_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = rar_pkg::S_DECODE;
        end
      end
      rar_pkg::S_DECODE: begin
        if (arith_mode) begin
          cnt_next   = rar_pkg::MUL_FIRST;
          state_next = rar_pkg::S_MUL;
        end else if (stat.mode == rar_pkg::MODE_RED) begin
          if (stat.b_den_zero) begin
            cmd.res_sel = rar_pkg::RES_PASS;
            state_next  = rar_pkg::S_OUT;
          end else if (stat.b_num_zero) begin
            cmd.res_sel = rar_pkg::RES_UNIT;
            state_next  = rar_pkg::S_OUT;
          end else begin
            cmd.gcd_init = 1'b1;
            state_next   = rar_pkg::S_GCD_TEST;
          end
        end else begin
          cmd.res_sel = rar_pkg::RES_UNIT;
          state_next  = rar_pkg::S_OUT;
        end
      end
      rar_pkg::S_MUL: begin
        cmd.mul_en = 1'b1;
        if (cnt == rar_pkg::MUL_LAST) state_next = rar_pkg::S_SUM;
        else cnt_next = cnt + 1'b1;
      end
      rar_pkg::S_SUM: begin
        cmd.res_sel = rar_pkg::RES_ARITH;
        state_next  = rar_pkg::S_OUT;
      end
      rar_pkg::S_GCD_TEST: begin
        cmd.div_start = 1'b1;
        if (stat.y_zero) begin
          // x holds the gcd: divide the numerator magnitude by it
          cmd.div_sel = rar_pkg::DIV_NUM;
          state_next  = rar_pkg::S_QN_DIV;
        end else begin
          cmd.div_sel = rar_pkg::DIV_GCD;
          state_next  = rar_pkg::S_GCD_DIV;
        end
      end
      rar_pkg::S_GCD_DIV: begin
        if (stat.div_done) begin
          cmd.gcd_swap = 1'b1;
          state_next   = rar_pkg::S_GCD_TEST;
        end
      end
      rar_pkg::S_QN_DIV: begin
        cmd.div_sel = rar_pkg::DIV_DEN;
        if (stat.div_done) begin
          cmd.save_qn   = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = rar_pkg::S_QD_DIV;
        end
      end
      rar_pkg::S_QD_DIV: begin
        if (stat.div_done) begin
          cmd.res_sel = rar_pkg::RES_REDUCED;
          state_next  = rar_pkg::S_OUT;
        end
      end
      rar_pkg::S_OUT: begin
        // Hand over once the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = rar_pkg::S_IDLE;
        end
      end
      default: state_next = rar_pkg::S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  // Divider completions only arrive while a division is awaited
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == rar_pkg::S_GCD_DIV || state == rar_pkg::S_QN_DIV ||
                       state == rar_pkg::S_QD_DIV))
    else $error("divider done outside a divide state");

  // A loaded result is offered on the next cycle
  a_load_offers: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("output loaded but not valid");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.out_load)
    else $error("output overwritten while stalled");

  // Operands only enter while no word is in flight
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == rar_pkg::S_IDLE)
    else $error("operand load outside idle");
`endif

endmodule

// ===== design/rational_arith_reduce.sv =====
// Rational arithmetic unit with Euclidean gcd reduction.
// Input channel in_valid/in_ready/in_data carries a mode and two fractions a and b;
// output channel out_valid/out_ready/out_data carries one result word per input word.
// Add, subtract, multiply and divide form cross products, unreduced; reduce divides
// both parts of b by the gcd of their magnitudes, signs kept. bad_den flags a zero
// operand or result denominator, and a zero b_den in reduce passes b through.
// One word is worked on at a time. Arithmetic modes pass decode, then one shared
// 16x16 multiplier forms the three products, then a sum step and the output step.
// Reduce runs one division per Euclid remainder step, then divides both magnitudes
// of b by the gcd; the shared divider yields one quotient bit a cycle.
// in_ready returns in the same cycle as out_valid rises.
// If the receiver stalls, the following result waits in the datapath's working
// register until the output register is taken. Reset (rst, synchronous) clears the
// controller and out_valid.
// Depends on rar_pkg, rar_ctrl, rar_dp.
module rational_arith_reduce (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rar_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rar_pkg::out_word_t out_data
);

  rar_pkg::dp_cmd_t  cmd;
  rar_pkg::dp_stat_t stat;

  rar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rar_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for rational_arith_reduce: directed and random words,
// checked against a predictor of the cross-product and gcd-reduction results.
// Depends on rar_pkg and the rational_arith_reduce RTL.
`timescale 1ns / 100ps

module tb;
  import rar_pkg::*;

  localparam int QUIET_WORDS = 150;        // last words sent with no idling
  localparam int RANDOM_WORDS = 1880;
  localparam int TAIL_CYCLES = 500;        // idle margin after the last result
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct {
    in_word_t word;
    bit       settle;                      // hold off until all results are in
  } stim_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  stim_t     stim_q[$];
  out_word_t predicted_q[$];
  int        fib[0:22];
  int        n_total;
  int        n_taken = 0;
  int        n_checked = 0;
  int        n_fail = 0;
  int        n_bad = 0;
  int        mode_cnt[0:4] = '{default: 0};
  int        gap_left = 0;
  int        stall_left = 0;
  longint    cycle_cnt = 0;

  rational_arith_reduce DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Euclid on magnitudes
  function automatic longint euclid_gcd(longint x, longint y);
    longint r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Predicted result word for one input word
  function automatic out_word_t fraction_result(in_word_t w);
    longint    an, ad, bn, bd, rn, rd, g;
    logic      flag;
    out_word_t r;
    an = $signed(w.a_num);
    ad = $signed(w.a_den);
    bn = $signed(w.b_num);
    bd = $signed(w.b_den);
    rn = 0;
    rd = 1;
    flag = 1'b0;
    case (w.mode)
      MODE_ADD: begin
        rn = an * bd + bn * ad;
        rd = ad * bd;
      end
      MODE_SUB: begin
        rn = an * bd - bn * ad;
        rd = ad * bd;
      end
      MODE_MUL: begin
        rn = an * bn;
        rd = ad * bd;
      end
      MODE_DIV: begin
        rn = an * bd;
        rd = ad * bn;
      end
      MODE_RED: begin
        // zero den passes b through, zero num gives 0/1
        if (bd == 0) begin
          rn = bn;
          rd = bd;
          flag = 1'b1;
        end else if (bn != 0) begin
          g = euclid_gcd(bn < 0 ? -bn : bn, bd < 0 ? -bd : bd);
          rn = bn / g;
          rd = bd / g;
        end
      end
      default: ;
    endcase
    if (w.mode <= MODE_DIV)
      flag = (ad == 0) || (bd == 0) || (rd[RES_W-1:0] == '0);
    r.res_num = rn[RES_W-1:0];
    r.res_den = rd[RES_W-1:0];
    r.bad_den = flag;
    return r;
  endfunction

  task automatic add_word(logic [MODE_W-1:0] m, int an, int ad, int bn, int bd,
                          bit settle = 1'b0);
    stim_t s;
    s.word.mode = m;
    s.word.a_num = an[PART_W-1:0];
    s.word.a_den = ad[PART_W-1:0];
    s.word.b_num = bn[PART_W-1:0];
    s.word.b_den = bd[PART_W-1:0];
    s.settle = settle;
    stim_q.push_back(s);
  endtask

  function automatic int rand_sign();
    return ($urandom_range(0, 1) != 0) ? -1 : 1;
  endfunction

  // Mostly full range, with extremes and small values mixed in
  function automatic int rand_part();
    case ($urandom_range(0, 9))
      0: return rand_sign() * 32767;
      1: return int'($urandom_range(0, 16)) - 8;
      2: return rand_sign() * int'($urandom_range(1, 255));
      default: return int'($urandom_range(0, 65534)) - 32767;
    endcase
  endfunction

  task automatic add_random_arith(bit settle);
    logic [MODE_W-1:0] m;
    int an, ad, bn, bd;
    m = MODE_W'($urandom_range(0, 3));
    an = rand_part();
    ad = rand_part();
    bn = rand_part();
    bd = rand_part();
    if ($urandom_range(0, 15) == 0) ad = 0;
    if ($urandom_range(0, 15) == 0) bd = 0;
    if (m == MODE_DIV && $urandom_range(0, 11) == 0) bn = 0;
    add_word(m, an, ad, bn, bd, settle);
  endtask

  // Reduce words: mostly pairs with a real common factor or long Euclid chains
  task automatic add_random_reduce(bit settle);
    int g, x, y, k, p, q, sc, bn, bd;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        g = $urandom_range(1, 200);
        x = $urandom_range(1, 32767 / g);
        y = $urandom_range(1, 32767 / g);
        bn = rand_sign() * g * x;
        bd = rand_sign() * g * y;
      end
      4, 5: begin
        k = $urandom_range(8, 22);
        p = fib[k];
        q = fib[k - 1];
        sc = $urandom_range(1, 32767 / p);
        if ($urandom_range(0, 1) != 0) begin
          bn = rand_sign() * p * sc;
          bd = rand_sign() * q * sc;
        end else begin
          bn = rand_sign() * q * sc;
          bd = rand_sign() * p * sc;
        end
      end
      6: begin
        bn = rand_part();
        bd = rand_part();
      end
      7: begin
        bn = 0;
        bd = rand_part();
      end
      8: begin
        bn = rand_part();
        bd = 0;
      end
      default: begin
        x = $urandom_range(1, 32767);
        bn = rand_sign() * x;
        bd = rand_sign() * x;
      end
    endcase
    add_word(MODE_RED, rand_part(), rand_part(), bn, bd, settle);
  endtask

  // Driver: valid held with a steady word until taken, random idle bursts
  always @(posedge clk) begin : drive
    logic      valid_n;
    out_word_t pred;
    stim_t     s;
    valid_n = in_valid;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pred = fraction_result(in_data);
        predicted_q.push_back(pred);
        if (pred.bad_den) n_bad++;
        if (in_data.mode <= MODE_RED) mode_cnt[in_data.mode]++;
        n_taken++;
        valid_n = 1'b0;
      end
      if (!valid_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          if (stim_q[0].settle && predicted_q.size() != 0) begin
            // wait for the block to drain
          end else if (stim_q.size() > QUIET_WORDS && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 4);
          end else begin
            s = stim_q.pop_front();
            in_data <= s.word;
            valid_n = 1'b1;
          end
        end
      end
    end
    in_valid <= valid_n;
  end

  // Monitor: random stall bursts on out_ready, field-by-field compare
  always @(posedge clk) begin : watch
    logic      rdy_n;
    out_word_t want;
    rdy_n = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          $error("result word with nothing outstanding: %0d/%0d bad_den %0b",
                 out_data.res_num, out_data.res_den, out_data.bad_den);
          n_fail++;
        end else begin
          want = predicted_q.pop_front();
          n_checked++;
          if (out_data.res_num !== want.res_num) begin
            $error("res_num: expected %0d, got %0d", want.res_num, out_data.res_num);
            n_fail++;
          end
          if (out_data.res_den !== want.res_den) begin
            $error("res_den: expected %0d, got %0d", want.res_den, out_data.res_den);
            n_fail++;
          end
          if (out_data.bad_den !== want.bad_den) begin
            $error("bad_den: expected %0b, got %0b", want.bad_den, out_data.bad_den);
            n_fail++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (stim_q.size() > QUIET_WORDS && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
      end else begin
        rdy_n = 1'b1;
      end
    end
    out_ready <= rdy_n;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    fib[0] = 1;
    fib[1] = 1;
    for (int i = 2; i <= 22; i++) fib[i] = fib[i - 1] + fib[i - 2];

    // Directed: every mode, extremes, zero denominators, reduce corners
    add_word(MODE_ADD, 1, 2, 1, 3);
    add_word(MODE_SUB, 32767, -32767, -32767, 32767);
    add_word(MODE_MUL, -32767, 32767, -32767, -32767);
    add_word(MODE_DIV, 32767, 1, -32767, -1);
    add_word(MODE_ADD, 32767, 32767, 32767, 32767);
    add_word(MODE_ADD, 5, 0, 3, 7);
    add_word(MODE_MUL, 5, 9, 3, 0);
    add_word(MODE_DIV, 4, 9, 0, 11);
    add_word(MODE_DIV, 4, 0, 0, 11);
    add_word(MODE_SUB, 0, 5, 0, 7);
    add_word(MODE_RED, 0, 0, 6, -4);
    add_word(MODE_RED, 1, 1, -12, -18);
    add_word(MODE_RED, -1, -1, 0, 7);
    add_word(MODE_RED, 0, 0, 5, 0);
    add_word(MODE_RED, 0, 0, 0, 0);
    add_word(MODE_RED, 0, 0, 7, 7);
    add_word(MODE_RED, 0, 0, -7, 7);
    add_word(MODE_RED, 0, 0, 28657, 17711);
    add_word(MODE_RED, 0, 0, -17711, 28657);
    add_word(MODE_RED, 0, 0, 32767, -32767);
    add_word(MODE_RED, 0, 0, 1, 32767);
    add_word(MODE_RED, 0, 0, 32767, 1);
    add_word(MODE_RED, 32767, -32767, -32767, 32767);

    // Random, with a full drain every few hundred words
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 99) < 55) add_random_arith(i % 400 == 0);
      else add_random_reduce(i % 400 == 0);
    end
    n_total = stim_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (n_taken < n_total) @(posedge clk);
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d words checked: add %0d, sub %0d, mul %0d, div %0d, reduce %0d",
             n_checked, mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3], mode_cnt[4]);
    $display("%0d results flagged a zero denominator, %0d cycles", n_bad, cycle_cnt);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
